// ===== hdl/bst_pkg.sv =====
// Bencode tokenizer shared types and constants.
// No dependencies.
package bst_pkg;
	typedef enum logic [2:0] {
		EV_INT = 3'd0, EV_STR_START = 3'd1, EV_STR_BYTE = 3'd2, EV_LIST = 3'd3,
		EV_DICT = 3'd4, EV_END = 3'd5, EV_ERROR = 3'd6
	} ev_kind_t;

	localparam logic [2:0] ERR_EOF = 3'd0;
	localparam logic [2:0] ERR_BAD_START = 3'd1;
	localparam logic [2:0] ERR_BAD_STRING = 3'd2;
	localparam logic [2:0] ERR_LEAD_ZERO = 3'd3;
	localparam logic [2:0] ERR_BAD_INT = 3'd4;
	localparam logic [2:0] ERR_KEY = 3'd5;
	localparam logic [2:0] ERR_DEEP = 3'd6;
	localparam logic [2:0] ERR_OVF = 3'd7;

	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_L = 8'h6c;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam logic [1:0] LVL_LIST = 2'd0;
	localparam logic [1:0] LVL_DICT_KEY = 2'd1;
	localparam logic [1:0] LVL_DICT_VAL = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic [63:0] value;
		logic [2:0] code;
		logic [5:0] depth;
		logic [31:0] offset;
		logic complete;
		logic last;
	} event_t;
endpackage

// ===== hdl/bencode_stream_tokenizer_core.sv =====
// Bencode stream tokenizer top level: parser front, event queue, output ports.
// Depends on bst_pkg, bst_front, bst_queue.
// Throughput: one byte per cycle while the queue has room; a byte giving two events fills two queue entries.
// An event is registered into the event queue when its byte transfers and is offered from the queue head.
// The parser itself takes each byte combinationally, with a combinational stack read.
// Reset (arst_n low) clears parser state and empties the queue at once.
module bencode_stream_tokenizer_core #(
	parameter int MAX_DEPTH = 32,
	parameter int LENGTH_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_buffer,
	input logic start_new,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] event_kind,
	output logic signed [63:0] event_value,
	output logic [2:0] error_code,
	output logic [5:0] nest_depth,
	output logic [31:0] byte_offset,
	output logic value_complete,
	output logic last_of_run
);
	import bst_pkg::*;

	logic room, evv;
	logic [1:0] evc;
	event_t e0, e1, rd;

	bst_front #(.MAX_DEPTH(MAX_DEPTH), .LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .end_of_buffer, .start_new,
		.ev_valid(evv), .ev_count(evc), .ev0(e0), .ev1(e1), .q_room(room)
	);

	bst_queue u_queue (
		.clk, .arst_n, .wr_valid(evv), .wr_count(evc), .wr0(e0), .wr1(e1),
		.room, .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(rd)
	);

	assign event_kind = rd.kind;
	assign event_value = rd.value;
	assign error_code = rd.code;
	assign nest_depth = rd.depth;
	assign byte_offset = rd.offset;
	assign value_complete = rd.complete;
	assign last_of_run = rd.last;
endmodule

// ===== hdl/bst_front.sv =====
// Front end: byte parser; turns each byte into up to two events.
// Depends on bst_pkg.
module bst_front #(
	parameter int MAX_DEPTH = 32,
	parameter int LENGTH_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_buffer,
	input logic start_new,
	output logic ev_valid,
	output logic [1:0] ev_count,
	output bst_pkg::event_t ev0,
	output bst_pkg::event_t ev1,
	input logic q_room
);
	import bst_pkg::*;

	typedef enum logic [2:0] {
		M_VALUE, M_STRLEN, M_STRDATA, M_INT_FIRST, M_INT_DIGITS
	} mode_t;

	localparam int SPW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	mode_t mode_q;
	logic [63:0] acc_q;
	logic neg_q, zlead_q, fin_q, fail_q;
	logic [LENGTH_WIDTH-1:0] srem_q;
	logic [SPW-1:0] sp_q;
	logic [31:0] off_q;
	logic [1:0] lvl_q [MAX_DEPTH];

	mode_t mode_n;
	logic [63:0] acc_n;
	logic neg_n, zlead_n, fin_n, fail_n;
	logic [LENGTH_WIDTH-1:0] srem_n;
	logic [SPW-1:0] sp_n;
	logic [31:0] off_c;
	logic wr_en, tog_en;
	logic [AW-1:0] wr_idx, tog_idx;
	logic [1:0] wr_val;
	logic [1:0] n;
	event_t e0, e1;

	// Magnitude accumulator times ten, with an overflow check.
	logic [3:0] dig;
	logic is_dig;
	logic [67:0] acc10;
	logic [63:0] lim_int;

	assign in_ready = q_room;

	always_comb begin
		logic cl_mode_value;
		logic [SPW-1:0] sp;
		logic [1:0] top;
		logic open;
		logic go;
		logic done;
		mode_t mode;
		logic [63:0] acc;
		logic neg, zl, fin, fl;
		logic [LENGTH_WIDTH-1:0] srem;
		event_t ev;
		go = in_valid && q_room;
		mode = start_new ? M_VALUE : mode_q;
		acc = start_new ? 64'd0 : acc_q;
		neg = start_new ? 1'b0 : neg_q;
		zl = start_new ? 1'b0 : zlead_q;
		srem = start_new ? '0 : srem_q;
		sp = start_new ? '0 : sp_q;
		fin = start_new ? 1'b0 : fin_q;
		fl = start_new ? 1'b0 : fail_q;
		off_c = start_new ? 32'd0 : off_q;
		is_dig = data_byte >= CH_ZERO && data_byte <= 8'h39;
		dig = 4'(data_byte - CH_ZERO);
		acc10 = {4'd0, acc} * 68'd10 + {64'd0, dig};
		lim_int = neg ? 64'h8000000000000000 : 64'h7fffffffffffffff;
		open = sp != '0;
		top = open ? lvl_q[AW'(sp - 1'b1)] : LVL_LIST;
		wr_en = 1'b0; wr_idx = AW'(sp); wr_val = LVL_LIST;
		tog_en = 1'b0; tog_idx = AW'(sp - 1'b1);
		n = 2'd0;
		done = 1'b0;
		cl_mode_value = 1'b0;
		ev = '0;
		ev.offset = off_c;
		e0 = '0; e1 = '0;
		if (!fin && !fl) begin
			case (mode)
				M_STRLEN: begin
					if (is_dig) begin
						if (acc10 > 68'((69'd1 << LENGTH_WIDTH) - 69'd1)) begin
							fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_OVF; n = 2'd1;
						end else acc = acc10[63:0];
					end else if (data_byte == CH_COLON) begin
						ev.kind = EV_STR_START; ev.value = acc; n = 2'd1;
						if (acc == 64'd0) cl_mode_value = 1'b1;
						else begin
							srem = LENGTH_WIDTH'(acc);
							mode = M_STRDATA;
						end
					end else begin
						fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_BAD_STRING; n = 2'd1;
					end
				end
				M_STRDATA: begin
					srem = srem - 1'b1;
					ev.kind = EV_STR_BYTE; ev.value = {56'd0, data_byte}; n = 2'd1;
					if (srem == '0) cl_mode_value = 1'b1;
				end
				M_INT_FIRST, M_INT_DIGITS: begin
					if (is_dig) begin
						if (zl) begin
							fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_LEAD_ZERO; n = 2'd1;
						end else if (acc10 > {4'd0, lim_int}) begin
							fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_OVF; n = 2'd1;
						end else begin
							acc = acc10[63:0];
							zl = acc10[63:0] == 64'd0;
							mode = M_INT_DIGITS;
						end
					end else if (data_byte == CH_MINUS && mode == M_INT_FIRST) begin
						neg = 1'b1; mode = M_INT_DIGITS;
					end else if (data_byte == CH_E) begin
						ev.kind = EV_INT; ev.value = neg ? (64'd0 - acc) : acc; n = 2'd1;
						cl_mode_value = 1'b1;
					end else begin
						fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_BAD_INT; n = 2'd1;
					end
				end
				default: begin
					if (data_byte == CH_E) begin
						if (open && (top == LVL_LIST || top == LVL_DICT_KEY)) begin
							sp = sp - 1'b1;
							ev.kind = EV_END; n = 2'd1;
							cl_mode_value = 1'b1;
						end else begin
							fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_BAD_START; n = 2'd1;
						end
					end else if (open && top == LVL_DICT_KEY && !is_dig) begin
						fl = 1'b1; ev.kind = EV_ERROR; n = 2'd1;
						ev.code = (data_byte == CH_I || data_byte == CH_L ||
							data_byte == CH_D) ? ERR_KEY : ERR_BAD_START;
					end else if (data_byte == CH_I) begin
						acc = '0; neg = 1'b0; zl = 1'b0; mode = M_INT_FIRST;
					end else if (data_byte == CH_L || data_byte == CH_D) begin
						if (32'(sp) >= 32'(MAX_DEPTH)) begin
							fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_DEEP; n = 2'd1;
						end else begin
							wr_en = go; wr_idx = AW'(sp);
							wr_val = (data_byte == CH_L) ? LVL_LIST : LVL_DICT_KEY;
							sp = sp + 1'b1;
							ev.kind = (data_byte == CH_L) ? EV_LIST : EV_DICT; n = 2'd1;
						end
					end else if (is_dig) begin
						acc = {60'd0, dig}; mode = M_STRLEN;
					end else begin
						fl = 1'b1; ev.kind = EV_ERROR; ev.code = ERR_BAD_START; n = 2'd1;
					end
				end
			endcase
			if (cl_mode_value) begin
				mode = M_VALUE;
				if (sp == '0) begin
					fin = 1'b1; done = 1'b1;
				end else begin
					// Popped entry is the parent; after a pop the index is the new top.
					tog_idx = AW'(sp - 1'b1);
					tog_en = go;
				end
			end
			ev.depth = 6'(sp);
			ev.complete = done;
			e0 = ev;
			if (end_of_buffer && !fin && !fl) begin
				fl = 1'b1;
				e1 = '0;
				e1.kind = EV_ERROR; e1.code = ERR_EOF; e1.offset = off_c; e1.depth = 6'(sp);
				if (n == 2'd0) begin
					e0 = e1; n = 2'd1;
				end else n = 2'd2;
			end
			if (n == 2'd1) e0.last = 1'b1;
			if (n == 2'd2) e1.last = 1'b1;
		end
		mode_n = mode; acc_n = acc; neg_n = neg; zlead_n = zl;
		srem_n = srem; sp_n = sp; fin_n = fin; fail_n = fl;
	end

	assign ev_valid = in_valid && q_room && n != 2'd0;
	assign ev_count = n;
	assign ev0 = e0;
	assign ev1 = e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_VALUE;
			acc_q <= '0; neg_q <= 1'b0; zlead_q <= 1'b0; srem_q <= '0;
			sp_q <= '0; off_q <= '0; fin_q <= 1'b0; fail_q <= 1'b0;
		end else if (in_valid && q_room) begin
			mode_q <= mode_n;
			acc_q <= acc_n; neg_q <= neg_n; zlead_q <= zlead_n; srem_q <= srem_n;
			sp_q <= sp_n; off_q <= off_c + 32'd1; fin_q <= fin_n; fail_q <= fail_n;
		end
	end

	// Level stack: push writes, value completion toggles dict key/value at new top.
	always_ff @(posedge clk) begin
		if (wr_en) lvl_q[wr_idx] <= wr_val;
		else if (tog_en) begin
			if (lvl_q[tog_idx] == LVL_DICT_KEY) lvl_q[tog_idx] <= LVL_DICT_VAL;
			else if (lvl_q[tog_idx] == LVL_DICT_VAL) lvl_q[tog_idx] <= LVL_DICT_KEY;
		end
	end
endmodule

// ===== hdl/bst_queue.sv =====
// Event queue between parser and output; takes up to two events per cycle.
// Depends on bst_pkg.
module bst_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	input logic [1:0] wr_count,
	input bst_pkg::event_t wr0,
	input bst_pkg::event_t wr1,
	output logic room,
	output logic rd_valid,
	input logic rd_ready,
	output bst_pkg::event_t rd_data
);
	import bst_pkg::*;

	localparam int DEPTH = 4;

	event_t mem_q [DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic pop;
	logic [1:0] push_n;

	assign room = cnt_q <= 3'(DEPTH - 2);
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data = mem_q[rp_q];
	assign pop = rd_valid && rd_ready;
	assign push_n = wr_valid ? wr_count : 2'd0;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wp_q] <= wr0;
		if (push_n == 2'd2) mem_q[wp_q + 2'd1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + push_n;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push_n} - {2'd0, pop};
		end
	end
endmodule

// ===== hdl/bst_checker.sv =====
// Port-level checks for the tokenizer top level, attached by bind.
// Depends on bst_pkg.
module bst_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] event_kind,
	input logic [2:0] error_code,
	input logic [5:0] nest_depth,
	input logic value_complete,
	input logic last_of_run
);
	import bst_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind))
		else $error("output changed while stalled");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_ERROR |-> error_code == 3'd0)
		else $error("error code on non-error event");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_complete |-> nest_depth == 6'd0 && last_of_run)
		else $error("completion with open containers");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_ERROR |-> last_of_run && !value_complete)
		else $error("error event not last");
endmodule

bind bencode_stream_tokenizer_core bst_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .event_kind, .error_code,
	.nest_depth, .value_complete, .last_of_run
);
